// ===== rtl/descriptor_slot_table_assert.svh =====
// Assertion macros used by the descriptor slot table RTL.
`ifndef DESCRIPTOR_SLOT_TABLE_ASSERT_SVH
`define DESCRIPTOR_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define DST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define DST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
`else
`define DST_ASSERT(lbl, clk, rstn, prop, msg)
`define DST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/dst_pkg.sv =====
package dst_pkg;

  typedef enum logic [2:0] {
    FUNC_ALLOC = 3'd0,
    FUNC_SET   = 3'd1,
    FUNC_GET   = 3'd2,
    FUNC_CLOSE = 3'd3,
    FUNC_PUT   = 3'd4,
    FUNC_SWEEP = 3'd5,
    FUNC_CLEAR = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_BAD_FD  = 3'd1,
    STATUS_BUSY    = 3'd2,
    STATUS_FULL    = 3'd3,
    STATUS_NOT_RSV = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [7:0] fd;
    logic [15:0]       handle;
    logic              cloexec;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  fd_out;
    logic [15:0] handle_out;
    logic        release_valid;
    logic [15:0] release_handle;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/descriptor_slot_table.sv =====
// Descriptor slot table. Each item carries one operation (alloc, set, get,
// close, put, sweep close-on-exec, clear all) and yields one result item, or
// one per released slot for sweep and clear all, the final one marked last.
// Slot handles live in a single-port-per-side RAM with registered read; the
// free/reserved/in-use state and close-on-exec flags are flops. For a
// single-slot operation the accept cycle issues the handle read (and picks
// the lowest group of 8 slots holding a free slot); the execute state then
// finishes the read-modify-write and loads the output register once it is empty or being read.
// Sweep and clear all walk the slots upward from slot 0 after accept, issuing
// a handle read for each released slot and emitting it once the output is free.
// A new item is taken only when the previous one has been fully issued; the
// output register lets the next item start while a result waits.
`include "descriptor_slot_table_assert.svh"

module descriptor_slot_table #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dst_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dst_pkg::out_item_t   out_item_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int NGRP  = (SLOTS + 7) / 8;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW  = NGRP * 8;
  localparam int HW    = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_WEMIT
  } state_e;

  state_e                 state_q, state_d;
  dst_pkg::in_item_t      op_q, op_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   ok_q, ok_d;
  logic [GW-1:0]          grp_q, grp_d;
  logic                   full_q, full_d;
  logic [SLOTS-1:0]       used_q, used_d;
  logic [SLOTS-1:0]       rsvd_q, rsvd_d;
  logic [SLOTS-1:0]       ce_q, ce_d;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic                   wclr_q, wclr_d;
  logic                   out_valid_q, out_valid_d;
  dst_pkg::out_item_t     out_q, out_d;

  logic                   accept;
  logic                   out_free;
  logic                   fd_ok;
  logic [IDX_W-1:0]       idx_in;
  logic [PADW-1:0]        free_pad;
  logic [NGRP-1:0]        grp_any;
  logic [GW-1:0]          grp_sel;
  logic [7:0]             grp_bits;
  logic [2:0]             bit_sel;
  logic [GW+2:0]          slot_w;
  logic [IDX_W-1:0]       alloc_slot;
  logic [SLOTS-1:0]       cand_in;
  logic [SLOTS-1:0]       cand_w;
  logic [SLOTS-1:0]       ptr_oh;
  logic                   more_cand;
  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic [HW-1:0]          hin_ext;
  logic [HW-1:0]          hout_ext;
  logic [15:0]            slot_handle;
  dst_pkg::out_item_t     res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Descriptor range check and slot index of the incoming item
  assign fd_ok  = !in_item_i.fd[7] && ($unsigned(in_item_i.fd) < 8'(SLOTS));
  assign idx_in = fd_ok ? in_item_i.fd[IDX_W-1:0] : '0;

  // Lowest free slot: pick the group at accept, the bit within it in the execute state
  assign free_pad = PADW'(~(used_q | rsvd_q));

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |free_pad[g*8 +: 8];
    end
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = GW'(g);
    end
  end

  assign grp_bits = free_pad[{grp_q, 3'b000} +: 8];

  always_comb begin
    bit_sel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = 3'(b);
    end
  end

  assign slot_w     = {grp_q, bit_sel};
  assign alloc_slot = slot_w[IDX_W-1:0];

  // Slots a walk must release
  assign cand_in   = used_q & ((in_item_i.func == dst_pkg::FUNC_CLEAR) ? '1 : ce_q);
  assign cand_w    = used_q & (wclr_q ? '1 : ce_q);
  assign ptr_oh    = SLOTS'(1) << ptr_q;
  assign more_cand = |(cand_w & ~ptr_oh);

  assign hin_ext     = HW'(op_q.handle);
  assign ram_wdata   = hin_ext[HANDLE_BITS-1:0];
  assign hout_ext    = HW'(ram_rdata);
  assign slot_handle = hout_ext[15:0];

  assign ram_re    = accept || ((state_q == S_WALK) && cand_w[ptr_q]);
  assign ram_raddr = accept ? idx_in : ptr_q;

  dst_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (SLOTS)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    ok_d        = ok_q;
    grp_d       = grp_q;
    full_d      = full_q;
    used_d      = used_q;
    rsvd_d      = rsvd_q;
    ce_d        = ce_q;
    ptr_d       = ptr_q;
    wclr_d      = wclr_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    res         = '0;
    res.last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = in_item_i;
          idx_d  = idx_in;
          ok_d   = fd_ok;
          grp_d  = grp_sel;
          full_d = ~|grp_any;
          ptr_d  = '0;
          wclr_d = (in_item_i.func == dst_pkg::FUNC_CLEAR);
          state_d = S_EXEC;
          if ((in_item_i.func == dst_pkg::FUNC_SWEEP) ||
              (in_item_i.func == dst_pkg::FUNC_CLEAR)) begin
            // Reserved slots drop silently on clear all
            if (in_item_i.func == dst_pkg::FUNC_CLEAR) rsvd_d = '0;
            if (|cand_in) state_d = S_WALK;
          end
        end
      end

      S_EXEC: begin
        case (op_q.func)
          dst_pkg::FUNC_ALLOC: begin
            if (full_q) begin
              res.status = dst_pkg::STATUS_FULL;
            end else begin
              res.fd_out = 6'(alloc_slot);
            end
          end
          dst_pkg::FUNC_SET: begin
            if (!ok_q) begin
              res.status = dst_pkg::STATUS_BAD_FD;
            end else if (!rsvd_q[idx_q]) begin
              res.status = dst_pkg::STATUS_NOT_RSV;
            end
          end
          dst_pkg::FUNC_GET: begin
            if (!ok_q || !used_q[idx_q]) begin
              res.status = dst_pkg::STATUS_BAD_FD;
            end else begin
              res.handle_out = slot_handle;
            end
          end
          dst_pkg::FUNC_CLOSE: begin
            if (!ok_q || !used_q[idx_q]) begin
              res.status = dst_pkg::STATUS_BAD_FD;
            end else begin
              res.release_valid  = 1'b1;
              res.release_handle = slot_handle;
            end
          end
          dst_pkg::FUNC_PUT: begin
            if (!ok_q) begin
              res.status = dst_pkg::STATUS_BAD_FD;
            end else if (rsvd_q[idx_q]) begin
              res.status = dst_pkg::STATUS_BUSY;
            end else if (used_q[idx_q]) begin
              res.release_valid  = 1'b1;
              res.release_handle = slot_handle;
            end
          end
          default: begin
          end
        endcase

        if (out_free) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (op_q.func)
            dst_pkg::FUNC_ALLOC: begin
              if (!full_q) rsvd_d[alloc_slot] = 1'b1;
            end
            dst_pkg::FUNC_SET: begin
              if (ok_q && rsvd_q[idx_q]) begin
                rsvd_d[idx_q] = 1'b0;
                used_d[idx_q] = 1'b1;
                ce_d[idx_q]   = op_q.cloexec;
                ram_we        = 1'b1;
              end
            end
            dst_pkg::FUNC_CLOSE: begin
              if (ok_q) used_d[idx_q] = 1'b0;
            end
            dst_pkg::FUNC_PUT: begin
              if (ok_q && !rsvd_q[idx_q]) begin
                used_d[idx_q] = 1'b1;
                ce_d[idx_q]   = op_q.cloexec;
                ram_we        = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // A candidate always remains at or above the pointer here
        if (cand_w[ptr_q]) begin
          state_d = S_WEMIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_WEMIT: begin
        res.fd_out         = 6'(ptr_q);
        res.release_valid  = 1'b1;
        res.release_handle = slot_handle;
        res.last           = !more_cand;
        if (out_free) begin
          out_d         = res;
          out_valid_d   = 1'b1;
          used_d[ptr_q] = 1'b0;
          ptr_d         = ptr_q + 1'b1;
          state_d       = more_cand ? S_WALK : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      grp_q       <= '0;
      full_q      <= 1'b0;
      used_q      <= '0;
      rsvd_q      <= '0;
      ce_q        <= '0;
      ptr_q       <= '0;
      wclr_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      ok_q        <= ok_d;
      grp_q       <= grp_d;
      full_q      <= full_d;
      used_q      <= used_d;
      rsvd_q      <= rsvd_d;
      ce_q        <= ce_d;
      ptr_q       <= ptr_d;
      wclr_q      <= wclr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `DST_ASSERT(a_slot_state_excl, clk_i, rst_ni, (used_q & rsvd_q) == '0,
              "slot both reserved and in use")
  `DST_ASSERT_IMP(a_wemit_cand, clk_i, rst_ni, state_q == S_WEMIT, cand_w[ptr_q],
                  "walk emitting a slot that is not a candidate")
  `DST_ASSERT_IMP(a_walk_has_cand, clk_i, rst_ni, state_q == S_WALK, cand_w != '0,
                  "walk running with nothing left to release")
  `DST_ASSERT_IMP(a_alloc_free, clk_i, rst_ni,
                  (state_q == S_EXEC) && (op_q.func == dst_pkg::FUNC_ALLOC) && !full_q,
                  !used_q[alloc_slot] && !rsvd_q[alloc_slot], "alloc picked a busy slot")
  `DST_ASSERT_IMP(a_release_ok, clk_i, rst_ni, out_valid_o && out_item_o.release_valid,
                  out_item_o.status == dst_pkg::STATUS_OK, "release with error status")

endmodule

// ===== rtl/dst_ram.sv =====
module dst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
